FILE: hw/rtl/isp_pkg.sv
// Package for the idle sleep power manager: configuration register indexes,
// reset values, interval levels and field widths.
// No dependencies.
package isp_pkg;

  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int BATT_W       = 7;
  localparam int LEVEL_W      = 2;
  localparam int COUNT_W_DEF  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLEEP_TIMEOUT = 3'd0,
    CFG_TIER_ONE      = 3'd1,
    CFG_TIER_TWO      = 3'd2,
    CFG_TIER_THREE    = 3'd3,
    CFG_LOW_BATTERY   = 3'd4
  } cfg_idx_t;

  typedef logic [LEVEL_W-1:0] level_t;

  localparam level_t LVL_0 = 2'd0;
  localparam level_t LVL_1 = 2'd1;
  localparam level_t LVL_2 = 2'd2;
  localparam level_t LVL_3 = 2'd3;

  localparam logic [CFG_W-1:0]  SLEEP_TIMEOUT_RST = 32'd600000;
  localparam logic [CFG_W-1:0]  TIER_ONE_RST      = 32'd1800000;
  localparam logic [CFG_W-1:0]  TIER_TWO_RST      = 32'd5400000;
  localparam logic [CFG_W-1:0]  TIER_THREE_RST    = 32'd10800000;
  localparam logic [BATT_W-1:0] LOW_BATTERY_RST   = 7'd20;

endpackage

FILE: hw/rtl/idle_sleep_power_manager.sv
// Inactivity sleep timer with tiered link-interval stepping.
// Depends on isp_pkg.
//
// The block takes one request per clock and returns one result per request,
// passing through the input register and then the result register,
// with all state updated in the single pass between them.
// Throughput is one request per cycle as long as results are taken; a stalled
// result holds the pipeline through out_ready. Configuration writes are
// applied at once and must only be issued while no request is in flight.
module idle_sleep_power_manager
  import isp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_tick,
  input  logic                 in_activity,
  input  logic                 in_wired_mode,
  input  logic                 in_mobile_mode,
  input  logic [BATT_W-1:0]    in_battery_percent,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_sleeping,
  output logic                 out_interval_request,
  output logic [LEVEL_W-1:0]   out_interval_level,
  output logic                 out_led_update,
  output logic                 out_led_low_battery,
  output logic [CFG_W-1:0]     out_time_until_sleep
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Configuration registers.
  logic [CFG_W-1:0]  sleep_timeout_r;
  logic [CFG_W-1:0]  tier_one_r;
  logic [CFG_W-1:0]  tier_two_r;
  logic [CFG_W-1:0]  tier_three_r;
  logic [BATT_W-1:0] low_battery_r;

  // Input register.
  logic              in_vld_r;
  logic              tick_r;
  logic              act_r;
  logic              wired_r;
  logic              mobile_r;
  logic [BATT_W-1:0] batt_r;

  // Block state.
  logic                   sleeping_r,   sleeping_nxt;
  logic [COUNT_WIDTH-1:0] idle_cnt_r,   idle_cnt_nxt;
  logic [COUNT_WIDTH-1:0] sleep_cnt_r,  sleep_cnt_nxt;
  logic                   low_flag_r,   low_flag_nxt;
  logic                   wired_seen_r, wired_seen_nxt;
  level_t                 cur_level_r,  cur_level_nxt;

  // Result register.
  logic               out_vld_r;
  logic               res_sleeping_r, res_sleeping_nxt;
  logic               res_req_r,      res_req_nxt;
  level_t             res_level_r,    res_level_nxt;
  logic               res_led_upd_r,  res_led_upd_nxt;
  logic               res_led_low_r,  res_led_low_nxt;
  logic [CFG_W-1:0]   res_until_r,    res_until_nxt;

  logic in_acc;
  logic adv;
  logic fire;

  assign adv      = !out_vld_r || out_ready;
  assign fire     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleep_timeout_r <= SLEEP_TIMEOUT_RST;
      tier_one_r      <= TIER_ONE_RST;
      tier_two_r      <= TIER_TWO_RST;
      tier_three_r    <= TIER_THREE_RST;
      low_battery_r   <= LOW_BATTERY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLEEP_TIMEOUT: sleep_timeout_r <= cfg_wdata;
        CFG_TIER_ONE:      tier_one_r      <= cfg_wdata;
        CFG_TIER_TWO:      tier_two_r      <= cfg_wdata;
        CFG_TIER_THREE:    tier_three_r    <= cfg_wdata;
        CFG_LOW_BATTERY:   low_battery_r   <= cfg_wdata[BATT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tick_r   <= in_tick;
      act_r    <= in_activity;
      wired_r  <= in_wired_mode;
      mobile_r <= in_mobile_mode;
      batt_r   <= in_battery_percent;
    end
  end

  // Single pass over one request.
  always_comb begin
    logic                   wired_chg;
    logic                   woken;
    logic                   slp;
    logic [COUNT_WIDTH-1:0] idle_v;
    logic [COUNT_WIDTH-1:0] slp_v;
    logic                   is_low;
    logic                   req;
    level_t                 req_lvl;
    level_t                 lvl;
    level_t                 target;
    logic                   flag;
    logic                   led_upd;
    logic                   led_low;
    logic                   due;
    logic [CMP_W-1:0]       diff;

    wired_chg = wired_r != wired_seen_r;
    woken     = sleeping_r && ((wired_chg && wired_r) || act_r);
    slp       = sleeping_r && !woken;
    req       = woken;
    req_lvl   = LVL_0;
    lvl       = woken ? LVL_0 : cur_level_r;
    target    = LVL_0;
    idle_v    = (wired_chg || act_r) ? '0 : idle_cnt_r;
    slp_v     = sleep_cnt_r;

    if (tick_r) begin
      if (idle_v != CNT_MAX) begin
        idle_v = idle_v + 1'b1;
      end
      if (slp && (slp_v != CNT_MAX)) begin
        slp_v = slp_v + 1'b1;
      end
    end

    is_low  = batt_r < low_battery_r;
    flag    = low_flag_r;
    led_upd = 1'b0;
    led_low = 1'b0;
    if (is_low != low_flag_r) begin
      flag = is_low;
      if (!wired_r) begin
        led_upd = 1'b1;
        led_low = is_low;
      end
    end

    priority if (slp && !mobile_r) begin
      priority if (CMP_W'(slp_v) >= CMP_W'(tier_three_r)) target = LVL_3;
      else if (CMP_W'(slp_v) >= CMP_W'(tier_two_r))       target = LVL_2;
      else if (CMP_W'(slp_v) >= CMP_W'(tier_one_r))       target = LVL_1;
      else                                                target = LVL_0;
      if (target != lvl) begin
        req     = 1'b1;
        req_lvl = target;
        lvl     = target;
      end
    end else if (wired_r) begin
      idle_v = '0;
    end else if (!slp && (CMP_W'(idle_v) >= CMP_W'(sleep_timeout_r))) begin
      // Sleep entry clears the battery flag after any LED update above.
      slp     = 1'b1;
      slp_v   = '0;
      req     = 1'b1;
      req_lvl = LVL_0;
      lvl     = LVL_0;
      flag    = 1'b0;
    end else begin
      target = LVL_0;
    end

    due  = CMP_W'(idle_v) >= CMP_W'(sleep_timeout_r);
    diff = CMP_W'(sleep_timeout_r) - CMP_W'(idle_v);

    sleeping_nxt     = slp;
    idle_cnt_nxt     = idle_v;
    sleep_cnt_nxt    = slp_v;
    low_flag_nxt     = flag;
    wired_seen_nxt   = wired_r;
    cur_level_nxt    = lvl;

    res_sleeping_nxt = slp;
    res_req_nxt      = req;
    res_level_nxt    = req ? req_lvl : lvl;
    res_led_upd_nxt  = led_upd;
    res_led_low_nxt  = led_low;
    res_until_nxt    = (slp || due) ? '0 : diff[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleeping_r   <= 1'b0;
      idle_cnt_r   <= '0;
      sleep_cnt_r  <= '0;
      low_flag_r   <= 1'b0;
      wired_seen_r <= 1'b0;
      cur_level_r  <= LVL_0;
    end else if (fire) begin
      sleeping_r   <= sleeping_nxt;
      idle_cnt_r   <= idle_cnt_nxt;
      sleep_cnt_r  <= sleep_cnt_nxt;
      low_flag_r   <= low_flag_nxt;
      wired_seen_r <= wired_seen_nxt;
      cur_level_r  <= cur_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_sleeping_r <= res_sleeping_nxt;
      res_req_r      <= res_req_nxt;
      res_level_r    <= res_level_nxt;
      res_led_upd_r  <= res_led_upd_nxt;
      res_led_low_r  <= res_led_low_nxt;
      res_until_r    <= res_until_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_is_sleeping      = res_sleeping_r;
  assign out_interval_request = res_req_r;
  assign out_interval_level   = res_level_r;
  assign out_led_update       = res_led_upd_r;
  assign out_led_low_battery  = res_led_low_r;
  assign out_time_until_sleep = res_until_r;

`ifndef ASSERT_OFF
  // A nonzero interval level only exists while asleep.
  a_level_needs_sleep: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_level_r != LVL_0) |-> sleeping_r)
    else $error("interval level nonzero while active");

  // A sleeping result always reports no time left.
  a_sleep_until_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_sleeping_r) |-> (res_until_r == '0))
    else $error("time until sleep nonzero while asleep");

  // An active result can only request level zero (wake).
  a_active_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_req_r && !res_sleeping_r) |-> (res_level_r == LVL_0))
    else $error("nonzero interval request while active");

  // The blink request is only raised together with an LED update.
  a_led_low_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_led_upd_r) |-> !res_led_low_r)
    else $error("low battery LED without update");
`endif

endmodule
